// File: rtl/core/dfmt_pkg.sv
// Shared constants and types of the decimal field formatter.
`default_nettype none

package dfmt_pkg;

  // Largest field in characters, and the widths that follow from it.
  localparam int unsigned MAX_WIDTH = 16;
  localparam int unsigned WIDTH_W   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned IDX_W     = $clog2(MAX_WIDTH);

  // Fixed widths of the beat fields.
  localparam int unsigned OP_W    = 2;
  localparam int unsigned MAG_W   = 32;
  localparam int unsigned FW_W    = 5;
  localparam int unsigned FRAC_W  = 4;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DIGIT_W = 4;

  // Reciprocal of ten: floor(x / 10) equals (x * RECIP_TEN) >> RECIP_SHIFT for 32-bit x.
  localparam logic [MAG_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned      RECIP_SHIFT = 35;

  // ASCII codes.
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] ASCII_POINT = 8'h2E;

  // Formatting modes; the unused code behaves as unsigned.
  typedef enum logic [OP_W-1:0] {
    OP_UNSIGNED = 2'd0,
    OP_SIGNED   = 2'd1,
    OP_FIXED    = 2'd2
  } op_e;

endpackage

`default_nettype wire

// File: rtl/core/dfmt_if.sv
// Handshake channels of the decimal field formatter: number in, characters out.
`default_nettype none

interface dfmt_in_if;
  logic                             valid;
  logic                             ready;
  logic [dfmt_pkg::OP_W-1:0]        op;
  logic [dfmt_pkg::MAG_W-1:0]       magnitude;
  logic                             negative;
  logic [dfmt_pkg::FW_W-1:0]        field_width;
  logic [dfmt_pkg::FRAC_W-1:0]      fraction_digits;

  modport source (
    output valid, op, magnitude, negative, field_width, fraction_digits,
    input  ready
  );
  modport sink (
    input  valid, op, magnitude, negative, field_width, fraction_digits,
    output ready
  );
endinterface

interface dfmt_out_if;
  logic                        valid;
  logic                        ready;
  logic [dfmt_pkg::CHAR_W-1:0] character;
  logic                        last;

  modport source (output valid, character, last, input ready);
  modport sink (input valid, character, last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dfmt_div10.sv
// Shared divide-by-ten unit: quotient by reciprocal multiplication, remainder digit.
`default_nettype none

module dfmt_div10 (
  input  wire logic [dfmt_pkg::MAG_W-1:0]   val_i,
  output logic      [dfmt_pkg::MAG_W-1:0]   quot_o,
  output logic      [dfmt_pkg::DIGIT_W-1:0] rem_o
);

  logic [2*dfmt_pkg::MAG_W-1:0] product;
  logic [dfmt_pkg::MAG_W-1:0]   times_ten;

  // One 32 by 32 multiplication; the shift is exact over the whole input range.
  always_comb begin
    product   = {{dfmt_pkg::MAG_W{1'b0}}, val_i} *
                {{dfmt_pkg::MAG_W{1'b0}}, dfmt_pkg::RECIP_TEN};
    quot_o    = dfmt_pkg::MAG_W'(product >> dfmt_pkg::RECIP_SHIFT);
    times_ten = (quot_o << 3) + (quot_o << 1);
    rem_o     = dfmt_pkg::DIGIT_W'(val_i - times_ten);
  end

endmodule

`default_nettype wire

// File: rtl/core/decimal_field_formatter.sv
// Top level of the decimal field formatter: sequencer, character buffer and output register.
//
// Usage: one beat on in_i carries a number (mode, magnitude, sign, field width and
// fraction digits); the block answers with exactly field_width beats on out_o, one
// ASCII character each, most significant first, with last set on the final one.
// A field width of zero gives no beats; widths above MAX_WIDTH are clipped.
// Timing: in_i.ready is high only while the block is idle. After acceptance the
// field is built one position per cycle, each digit coming from the shared
// divide-by-ten unit, then the sign state places any minus sign, then the
// characters leave through an output register at one per cycle while out_o.ready
// is high. The multiplier in the divide-by-ten unit sets the clock period.
// When out_o.ready is low the current character is held and the sequencer waits;
// the last character of a field may still be waiting while the next item is taken.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops out_o.valid.
`default_nettype none

module decimal_field_formatter (
  input wire logic clk_i,
  input wire logic rst_ni,
  dfmt_in_if.sink    in_i,
  dfmt_out_if.source out_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [dfmt_pkg::MAG_W-1:0]   val_q;
  logic [dfmt_pkg::WIDTH_W-1:0] w_q;
  logic [dfmt_pkg::FRAC_W-1:0]  prec_q;
  logic [dfmt_pkg::WIDTH_W-1:0] start_q;
  logic                         neg_q;
  logic [dfmt_pkg::IDX_W-1:0]   pos_q;
  logic [dfmt_pkg::WIDTH_W-1:0] used_q;
  logic [dfmt_pkg::IDX_W-1:0]   idx_q;

  logic [dfmt_pkg::CHAR_W-1:0]  char_q [dfmt_pkg::MAX_WIDTH];

  logic                         out_valid_q;
  logic [dfmt_pkg::CHAR_W-1:0]  out_char_q;
  logic                         out_last_q;

  logic [dfmt_pkg::MAG_W-1:0]   quot;
  logic [dfmt_pkg::DIGIT_W-1:0] rem;

  logic                         in_fire;
  logic [dfmt_pkg::WIDTH_W-1:0] w_sat;
  logic [dfmt_pkg::FRAC_W-1:0]  prec_in;
  logic                         neg_in;
  logic                         is_frac;
  logic                         is_point;
  logic                         is_lead;
  logic                         take_digit;
  logic [dfmt_pkg::CHAR_W-1:0]  conv_char;
  logic                         conv_done;
  logic                         out_load;
  logic                         put_minus;

  dfmt_div10 u_div10 (
    .val_i  (val_q),
    .quot_o (quot),
    .rem_o  (rem)
  );

  // Decode of the incoming beat.
  always_comb begin
    in_fire = in_i.valid && in_i.ready;
    if (in_i.field_width > dfmt_pkg::FW_W'(dfmt_pkg::MAX_WIDTH)) begin
      w_sat = dfmt_pkg::WIDTH_W'(dfmt_pkg::MAX_WIDTH);
    end else begin
      w_sat = dfmt_pkg::WIDTH_W'(in_i.field_width);
    end
    prec_in = (in_i.op == dfmt_pkg::OP_FIXED) ? in_i.fraction_digits : '0;
    case (in_i.op)
      dfmt_pkg::OP_SIGNED: neg_in = in_i.negative && (in_i.magnitude != '0);
      dfmt_pkg::OP_FIXED:  neg_in = in_i.negative;
      default:             neg_in = 1'b0;
    endcase
  end

  // Character for the current position, counted from the right-hand end.
  always_comb begin
    is_frac    = dfmt_pkg::WIDTH_W'(pos_q) < dfmt_pkg::WIDTH_W'(prec_q);
    is_point   = (prec_q != '0) && (dfmt_pkg::WIDTH_W'(pos_q) == dfmt_pkg::WIDTH_W'(prec_q));
    is_lead    = (val_q != '0) || (dfmt_pkg::WIDTH_W'(pos_q) == start_q);
    take_digit = is_frac || (!is_point && is_lead);
    if (take_digit) begin
      conv_char = dfmt_pkg::ASCII_ZERO + dfmt_pkg::CHAR_W'(rem);
    end else if (is_point) begin
      conv_char = dfmt_pkg::ASCII_POINT;
    end else begin
      conv_char = dfmt_pkg::ASCII_SPACE;
    end
    conv_done = dfmt_pkg::WIDTH_W'(pos_q) == (w_q - 1'b1);
    put_minus = neg_q && ((used_q + 1'b1) < w_q);
    out_load  = !out_valid_q || out_o.ready;
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (w_sat != '0)) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (conv_done) state_d = ST_SIGN;
      end
      ST_SIGN: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_load && (idx_q == '0)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers of the item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      used_q <= '0;
      idx_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          pos_q  <= '0;
          used_q <= '0;
        end
        ST_CONV: begin
          pos_q <= pos_q + 1'b1;
          if (conv_char != dfmt_pkg::ASCII_SPACE) used_q <= used_q + 1'b1;
        end
        ST_SIGN: idx_q <= dfmt_pkg::IDX_W'(w_q - 1'b1);
        ST_EMIT: begin
          if (out_load && (idx_q != '0)) idx_q <= idx_q - 1'b1;
        end
        default: begin
          pos_q <= '0;
        end
      endcase
    end
  end

  // Payload of the item and the value being divided down.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      val_q   <= in_i.magnitude;
      w_q     <= w_sat;
      prec_q  <= prec_in;
      start_q <= (prec_in != '0) ? dfmt_pkg::WIDTH_W'(prec_in) + 1'b1 : '0;
      neg_q   <= neg_in;
    end else if ((state_q == ST_CONV) && take_digit) begin
      val_q <= quot;
    end
  end

  // Character buffer: one write per cycle, read into the output register.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CONV) begin
      char_q[pos_q] <= conv_char;
    end else if ((state_q == ST_SIGN) && put_minus) begin
      char_q[used_q[dfmt_pkg::IDX_W-1:0]] <= dfmt_pkg::ASCII_MINUS;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_EMIT) && out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_EMIT) && out_load) begin
      out_char_q <= char_q[idx_q];
      out_last_q <= (idx_q == '0);
    end
  end

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.character = out_char_q;
  assign out_o.last      = out_last_q;

  // Only the closing character of a field may still wait while the next one is built.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (state_q == ST_CONV || state_q == ST_SIGN)) |-> out_last_q)
    else $error("a non-final character is pending while a new field is built");

  // Non-space characters can never outnumber the positions already built.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> (used_q <= dfmt_pkg::WIDTH_W'(pos_q)))
    else $error("character count exceeds the position count");

  // The read pointer stays inside the field while characters are sent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (dfmt_pkg::WIDTH_W'(idx_q) < w_q))
    else $error("read pointer outside the field");

  // Leaving the send phase coincides with loading the closing character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EMIT) && (state_d == ST_IDLE)) |=> (out_valid_q && out_last_q))
    else $error("field ended without a closing character");

endmodule

`default_nettype wire

// File: dv/tb_decimal_field_formatter.sv
// Self-checking testbench of the decimal field formatter: numbers in, predicted ASCII fields out.
`default_nettype none

module tb_decimal_field_formatter;
  import dfmt_pkg::*;

  // The code that the mode field can carry but that has no mode of its own.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  // Idle percentage on each side, run length, post-drain wait and watchdog.
  localparam int unsigned IDLE_PCT     = 22;
  localparam int unsigned RANDOM_ITEMS = 146;
  localparam int unsigned DRAIN_WAIT   = 2 * MAX_WIDTH + 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // One number as it travels on the input channel.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [MAG_W-1:0]  magnitude;
    logic              negative;
    logic [FW_W-1:0]   field_width;
    logic [FRAC_W-1:0] fraction_digits;
  } number_t;

  // One character beat as it leaves the block.
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } char_beat_t;

  // Predicts the field of each accepted number and checks the characters in order.
  class char_scoreboard;
    char_beat_t pending_chars[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Builds the expected field from the least significant position upwards.
    function void note_number(number_t num);
      logic [CHAR_W-1:0] text [MAX_WIDTH];
      logic [MAG_W-1:0]  rest;
      logic [CHAR_W-1:0] c;
      logic              minus;
      int unsigned       w, prec, start, used;
      char_beat_t        beat;

      w = (num.field_width > MAX_WIDTH) ? MAX_WIDTH : num.field_width;
      if (w == 0) return;
      prec  = (num.op == OP_FIXED) ? num.fraction_digits : 0;
      start = (prec > 0) ? prec + 1 : 0;
      rest  = num.magnitude;
      used  = 0;
      // Signed mode hides the minus on zero; fixed mode always keeps it.
      if (num.op == OP_SIGNED) minus = num.negative && (rest != 0);
      else if (num.op == OP_FIXED) minus = num.negative;
      else minus = 1'b0;

      for (int unsigned p = 0; p < w; p++) begin
        if (p < prec) begin
          c    = ASCII_ZERO + CHAR_W'(rest % 10);
          rest = rest / 10;
        end else if (prec > 0 && p == prec) begin
          c = ASCII_POINT;
        end else if (rest != 0 || p == start) begin
          c    = ASCII_ZERO + CHAR_W'(rest % 10);
          rest = rest / 10;
        end else begin
          c = ASCII_SPACE;
        end
        if (c != ASCII_SPACE) used++;
        text[w - 1 - p] = c;
      end

      // The minus only appears when it leaves at least one leading space.
      if (minus && used + 1 < w) text[w - 1 - used] = ASCII_MINUS;

      for (int unsigned p = 0; p < w; p++) begin
        beat.character = text[p];
        beat.last      = (p == w - 1);
        pending_chars.push_back(beat);
      end
    endfunction

    // Compares one accepted character beat with the oldest expectation.
    function void check_char(logic [CHAR_W-1:0] character, logic last);
      char_beat_t want;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character beat: expected none, actual 8'h%02h last %0b",
                 $time, character, last);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      if (character !== want.character) begin
        $display("%0t: character mismatch: expected 8'h%02h, actual 8'h%02h",
                 $time, want.character, character);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, last);
        errors++;
      end
    endfunction

    function int unsigned pending_count();
      return pending_chars.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        steady;
  int unsigned cycles;
  char_scoreboard sb;

  dfmt_in_if  num_ch ();
  dfmt_out_if char_ch ();

  decimal_field_formatter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (num_ch),
    .out_o  (char_ch)
  );

  always #10 clk_i = ~clk_i;

  // Watchdog: a hung or starved run ends here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d characters still expected", $time, sb.pending_count());
      $display("tb_decimal_field_formatter: FAIL");
      $finish;
    end
  end

  // Receiver back-pressure, changed at the falling edge.
  always @(negedge clk_i) begin
    char_ch.ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Character beats are taken at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && char_ch.valid && char_ch.ready) begin
      sb.check_char(char_ch.character, char_ch.last);
    end
  end

  function automatic number_t make_number(logic [OP_W-1:0] op, logic [MAG_W-1:0] mag,
                                          logic neg, logic [FW_W-1:0] fw,
                                          logic [FRAC_W-1:0] frac);
    number_t num;
    num.op              = op;
    num.magnitude       = mag;
    num.negative        = neg;
    num.field_width     = fw;
    num.fraction_digits = frac;
    return num;
  endfunction

  // Presents one number after an optional random gap and waits for its beat.
  task automatic send_number(number_t num);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      num_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    num_ch.valid           = 1'b1;
    num_ch.op              = num.op;
    num_ch.magnitude       = num.magnitude;
    num_ch.negative        = num.negative;
    num_ch.field_width     = num.field_width;
    num_ch.fraction_digits = num.fraction_digits;
    @(posedge clk_i);
    while (!num_ch.ready) @(posedge clk_i);
    sb.note_number(num);
    @(negedge clk_i);
    // The beat has been taken, so the channel falls idle until the next number.
    num_ch.valid = 1'b0;
  endtask

  task automatic wait_for_drain();
    while (sb.pending_count() != 0) @(negedge clk_i);
  endtask

  initial begin
    number_t          num;
    logic [MAG_W-1:0] pow;
    int unsigned      digits;

    sb                     = new();
    cycles                 = 0;
    steady                 = 1'b0;
    rst_ni                 = 1'b0;
    num_ch.valid           = 1'b0;
    num_ch.op              = OP_UNSIGNED;
    num_ch.magnitude       = '0;
    num_ch.negative        = 1'b0;
    num_ch.field_width     = '0;
    num_ch.fraction_digits = '0;
    char_ch.ready          = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed numbers: field extremes, every mode and the corner cases.
    send_number(make_number(OP_UNSIGNED, 32'd0, 1'b0, 5'd1, 4'd0));
    send_number(make_number(OP_UNSIGNED, 32'hFFFF_FFFF, 1'b0, 5'd16, 4'd0));
    send_number(make_number(OP_UNSIGNED, 32'hFFFF_FFFF, 1'b0, 5'd5, 4'd15));
    send_number(make_number(OP_UNSIGNED, 32'd1_000_000_000, 1'b1, 5'd10, 4'd0));
    send_number(make_number(OP_UNSIGNED, 32'd77, 1'b1, 5'd6, 4'd3));
    send_number(make_number(OP_SIGNED, 32'd12345, 1'b1, 5'd8, 4'd0));
    send_number(make_number(OP_SIGNED, 32'd0, 1'b1, 5'd4, 4'd0));
    send_number(make_number(OP_SIGNED, 32'd1_234_567, 1'b1, 5'd8, 4'd0));
    send_number(make_number(OP_SIGNED, 32'd42, 1'b0, 5'd3, 4'd0));
    send_number(make_number(OP_SIGNED, 32'hFFFF_FFFF, 1'b1, 5'd11, 4'd0));
    send_number(make_number(OP_SIGNED, 32'hFFFF_FFFF, 1'b1, 5'd12, 4'd0));
    send_number(make_number(OP_SIGNED, 32'd9, 1'b1, 5'd1, 4'd0));
    send_number(make_number(OP_FIXED, 32'd31415, 1'b1, 5'd10, 4'd4));
    send_number(make_number(OP_FIXED, 32'd0, 1'b1, 5'd6, 4'd2));
    send_number(make_number(OP_FIXED, 32'd0, 1'b1, 5'd3, 4'd0));
    send_number(make_number(OP_FIXED, 32'd123456, 1'b1, 5'd4, 4'd15));
    send_number(make_number(OP_FIXED, 32'hFFFF_FFFF, 1'b1, 5'd16, 4'd14));
    send_number(make_number(OP_FIXED, 32'd5, 1'b0, 5'd4, 4'd3));
    send_number(make_number(OP_FIXED, 32'd7, 1'b1, 5'd2, 4'd1));
    send_number(make_number(OP_FIXED, 32'hFFFF_FFFF, 1'b1, 5'd16, 4'd1));
    send_number(make_number(OP_SPARE, 32'd77, 1'b1, 5'd5, 4'd2));
    send_number(make_number(OP_SIGNED, 32'd55, 1'b1, 5'd0, 4'd0));
    send_number(make_number(OP_SIGNED, 32'd987654, 1'b1, 5'd17, 4'd0));
    send_number(make_number(OP_FIXED, 32'd2718281, 1'b1, 5'd31, 4'd8));

    // Random numbers: mostly well-formed fields, some out-of-range noise.
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 40 && i < 80);
      // Once, the sender holds off until every field has come out.
      if (i == 100) wait_for_drain();

      case ($urandom_range(0, 3))
        0: num.magnitude = $urandom;
        1: num.magnitude = $urandom_range(0, 99);
        2: begin
          // Around a power of ten, where the digit count changes.
          digits = $urandom_range(1, 9);
          pow    = 1;
          repeat (digits) pow = pow * 10;
          num.magnitude = pow - $urandom_range(0, 1);
        end
        default: num.magnitude = $urandom_range(0, 99999);
      endcase
      num.negative = 1'($urandom_range(0, 1));

      if ($urandom_range(0, 99) < 85) begin
        num.op          = op_e'($urandom_range(OP_UNSIGNED, OP_FIXED));
        num.field_width = FW_W'($urandom_range(1, MAX_WIDTH));
        if (num.op == OP_FIXED && num.field_width >= 3)
          num.fraction_digits = FRAC_W'($urandom_range(0, num.field_width - 2));
        else
          num.fraction_digits = FRAC_W'($urandom_range(0, 1));
      end else begin
        num.op              = OP_W'($urandom_range(0, 3));
        num.field_width     = FW_W'($urandom_range(0, 31));
        num.fraction_digits = FRAC_W'($urandom_range(0, 15));
      end
      send_number(num);
    end

    steady       = 1'b0;
    num_ch.valid = 1'b0;
    wait_for_drain();
    repeat (DRAIN_WAIT) @(negedge clk_i);

    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("tb_decimal_field_formatter: PASS");
    end else begin
      $display("tb_decimal_field_formatter: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
